// ===== hdl/isqb_pkg.sv =====
// isqb_pkg: shared widths, constants and control types for the bisection square root unit
// no dependencies; imported by the datapath, the controller and the top level
package isqb_pkg;

    localparam int OPERAND_W = 32;
    localparam int ROOT_W    = 17;
    // bounds never exceed the upper start value, which fits in 16 bits
    localparam int BOUND_W   = 16;
    localparam int MAG_W     = OPERAND_W - 1;

    // 46341 squared exceeds the largest positive operand, so it is a valid upper bound
    localparam logic [BOUND_W-1:0] HI_INIT  = 16'd46341;
    localparam logic [ROOT_W-1:0]  ROOT_NEG = {ROOT_W{1'b1}};

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } isqb_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic done;
    } isqb_sts_t;

endpackage

// ===== hdl/isqb_dpath.sv =====
// isqb_dpath: operand, bound and result registers with one bisection step per cycle
// depends on isqb_pkg
module isqb_dpath (
    input  logic                               clk,
    input  isqb_pkg::isqb_cmd_t                cmd,
    output isqb_pkg::isqb_sts_t                sts,
    input  logic [isqb_pkg::OPERAND_W-1:0]     operand,
    output logic signed [isqb_pkg::ROOT_W-1:0] root
);
    import isqb_pkg::*;

    logic [MAG_W-1:0]       x_reg;
    logic                   neg_reg;
    logic [BOUND_W-1:0]     lo_reg;
    logic [BOUND_W-1:0]     hi_reg;
    logic [ROOT_W-1:0]      root_reg;

    logic [BOUND_W:0]       sum;
    logic [BOUND_W-1:0]     mid;
    logic [2*BOUND_W-1:0]   mid_sq;
    logic                   too_big;
    logic [BOUND_W-1:0]     gap;

    // midpoint from a sum one bit wider than the bounds
    assign sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = sum[BOUND_W:1];
    assign mid_sq  = mid * mid;
    assign too_big = mid_sq > {{(2*BOUND_W-MAG_W){1'b0}}, x_reg};
    assign gap     = hi_reg - lo_reg;

    // converged once the bounds are adjacent, or at once for a negative operand
    assign sts.done = neg_reg || (gap == {{(BOUND_W-1){1'b0}}, 1'b1});
    assign root     = root_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= operand[MAG_W-1:0];
            neg_reg <= operand[OPERAND_W-1];
            lo_reg  <= '0;
            hi_reg  <= HI_INIT;
        end
        else if (cmd.step)
        begin
            if (too_big)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid;
            end
        end
        if (cmd.emit)
        begin
            root_reg <= neg_reg ? ROOT_NEG : {1'b0, lo_reg};
        end
    end

endmodule

// ===== hdl/isqb_ctrl.sv =====
// isqb_ctrl: sequencing state machine and output valid flag
// depends on isqb_pkg
module isqb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output isqb_pkg::isqb_cmd_t cmd,
    input  isqb_pkg::isqb_sts_t sts
);
    import isqb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.load = in_valid && in_ready;
        cmd.step = (state_reg == ST_RUN) && !sts.done;
        cmd.emit = (state_reg == ST_RUN) && sts.done && out_free;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // a finished word waits here until the output register frees
                if (cmd.emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/integer_sqrt_bisection_unit.sv =====
// integer_sqrt_bisection_unit: top level of the bisection square root unit
// depends on isqb_pkg, isqb_ctrl and isqb_dpath
//
// computes the floor square root of a signed 32-bit operand word; a negative
// operand gives -1 (all ones on root). the root is found by bisection: the
// bounds start at 0 and 46341 (whose square already exceeds any positive
// operand) and each cycle one midpoint is squared by a single 16x16
// multiplier and compared against the operand, keeping the half that holds
// the root. one word is worked on at a time: the bounds are loaded at the
// accepting edge, the search runs until the bounds are adjacent (a negative
// operand skips it), and the root is then loaded into the output register
// once that register is free. in_ready returns at the edge that loads the
// root, so one word occupies the unit from its accepting edge until then.
// in_ready is high only while no search is in flight; the output register
// holds a finished word independently, so the next operand is taken while
// the previous root still waits for out_ready. if the next search finishes
// before the output register is freed, it holds its result until then.
// nothing is kept from one word to the next.
module integer_sqrt_bisection_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [isqb_pkg::OPERAND_W-1:0] operand,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [isqb_pkg::ROOT_W-1:0] root
);
    import isqb_pkg::*;

    // command and status between the sequencer and the datapath
    isqb_cmd_t cmd;
    isqb_sts_t sts;

    // sequencer: owns the handshake and decides when to load, step and emit
    isqb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: bounds, midpoint squaring and the result register
    isqb_dpath u_dpath (
        .clk     (clk),
        .cmd     (cmd),
        .sts     (sts),
        .operand (operand),
        .root    (root)
    );

endmodule

// ===== hdl/isqb_checker.sv =====
// isqb_checker: port-level assertions for the bisection square root unit
// depends on the top level's ports only; bound to integer_sqrt_bisection_unit below
module isqb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [31:0] operand,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [16:0] root
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root))
        else $error("result word changed while stalled");

    // only one word in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second operand taken during a search");

    // a result is either -1 or a root in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (root == 17'h1FFFF) || (!root[16] && root <= 17'sd46340))
        else $error("root out of range");

    // a negative operand with a free output gives -1 with no search steps
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operand[31] && !out_valid
        |=> ##1 out_valid && (root == 17'h1FFFF))
        else $error("negative operand did not give -1");

endmodule

bind integer_sqrt_bisection_unit isqb_checker u_isqb_checker (.*);
